FILE: rtl/bse_pkg.sv
// bse_pkg: shared types, constants and a helper function for the bicubic spline evaluator
// no dependencies
`default_nettype none

package bse_pkg;

    // default table sizes
    localparam int MAX_FRAG_BREAKS_DEF = 32;
    localparam int MAX_PREC_BREAKS_DEF = 32;
    localparam int COEFS_PER_CELL      = 16;

    // field widths
    localparam int MASS_W   = 32;
    localparam int COEF_W   = 48;
    localparam int CNT_W    = 6;
    localparam int SEG_W    = 8;
    localparam int SLOT_W   = 4;
    localparam int QUEUE_DEPTH = 4;

    // reset value of the break counts
    localparam logic [CNT_W-1:0] CNT_RESET = 6'd32;

    // -1.0 in Q8.40
    localparam logic signed [COEF_W-1:0] NEG_ONE_Q40 = -48'sh0100_0000_0000;

    // request codes
    typedef enum logic [1:0] {
        REQ_EVAL = 2'd0,
        REQ_FRAG = 2'd1,
        REQ_PREC = 2'd2,
        REQ_COEF = 2'd3
    } t_req;

    // configuration register indexes
    typedef enum logic {
        CFG_FRAG_CNT = 1'b0,
        CFG_PREC_CNT = 1'b1
    } t_cfg;

    // job handed from front to back
    typedef struct packed {
        logic                     is_coef;
        logic                     oor;
        logic [SEG_W-1:0]         p_seg;
        logic [SEG_W-1:0]         f_seg;
        logic [SLOT_W-1:0]        slot;
        logic signed [COEF_W-1:0] value;
        logic [MASS_W-1:0]        x_off;
        logic [MASS_W-1:0]        y_off;
    } t_job;

    // saturate a 50-bit sum to the signed 48-bit range
    function automatic logic signed [COEF_W-1:0] sat48(input logic signed [COEF_W+1:0] a);
        logic signed [COEF_W-1:0] r;
        if (a > $signed({3'b000, {(COEF_W-1){1'b1}}})) begin
            r = {1'b0, {(COEF_W-1){1'b1}}};
        end else if (a < $signed({3'b111, {(COEF_W-1){1'b0}}})) begin
            r = {1'b1, {(COEF_W-1){1'b0}}};
        end else begin
            r = a[COEF_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bse_req_if.sv
// bse_req_if: request channel of the spline evaluator (valid/ready plus request fields)
// no dependencies
`default_nettype none

interface bse_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         req_type;
    logic [31:0]        prec_mass;
    logic [31:0]        frag_mass;
    logic [31:0]        break_mass;
    logic [4:0]         break_slot;
    logic [4:0]         prec_segment;
    logic [4:0]         frag_segment;
    logic [3:0]         coef_slot;
    logic signed [47:0] coef_value;

    modport source (
        output valid, req_type, prec_mass, frag_mass, break_mass, break_slot,
               prec_segment, frag_segment, coef_slot, coef_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, prec_mass, frag_mass, break_mass, break_slot,
               prec_segment, frag_segment, coef_slot, coef_value,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/bse_rsp_if.sv
// bse_rsp_if: result channel of the spline evaluator (valid/ready plus result fields)
// no dependencies
`default_nettype none

interface bse_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] spline_value;
    logic               out_of_range;

    modport source (output valid, spline_value, out_of_range, input ready);
    modport sink   (input valid, spline_value, out_of_range, output ready);
endinterface

`default_nettype wire

FILE: rtl/bse_ram.sv
// bse_ram: generic simple dual-port RAM, one write and one registered read per cycle
// no dependencies
`default_nettype none

module bse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/bse_queue.sv
// bse_queue: short job queue between front and back
// depends on bse_pkg
`default_nettype none

module bse_queue import bse_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_job      o_head
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job            r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [PW:0]     r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bse_front.sv
// bse_front: accepts requests, loads break tables, range checks and segment search
// depends on bse_pkg, bse_req_if, bse_ram
`default_nettype none

module bse_front import bse_pkg::*; #(
    parameter int MAX_FRAG_BREAKS = MAX_FRAG_BREAKS_DEF,
    parameter int MAX_PREC_BREAKS = MAX_PREC_BREAKS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    bse_req_if.sink               req,
    input  wire logic [CNT_W-1:0] i_frag_cnt,
    input  wire logic [CNT_W-1:0] i_prec_cnt,
    input  wire logic             i_q_full,
    output logic                  o_q_push,
    output t_job                  o_q_job
);

    localparam int FAW = $clog2(MAX_FRAG_BREAKS);
    localparam int PAW = $clog2(MAX_PREC_BREAKS);
    localparam int FCW = $clog2(MAX_FRAG_BREAKS + 1);
    localparam int PCW = $clog2(MAX_PREC_BREAKS + 1);
    localparam int IW  = (FCW > PCW) ? FCW : PCW;

    typedef enum logic [2:0] {S_IDLE, S_SWEEP, S_SEG, S_SEGW, S_PUSH} t_state;

    t_state            r_state;
    logic [31:0]       r_pm, r_fm;
    logic [IW-1:0]     r_idx, r_ridx;
    logic              r_rv;
    logic [FCW-1:0]    r_kf, r_segf;
    logic [PCW-1:0]    r_kp, r_segp;
    logic [31:0]       r_f0, r_fn2, r_p0, r_pn2, r_fs, r_ps;

    logic [FCW-1:0]    w_nf, w_segf;
    logic [PCW-1:0]    w_np, w_segp;
    logic [IW-1:0]     w_nmax;
    logic              w_accept;
    t_req              w_type;
    logic              w_coef_ok;
    logic              w_oor;
    logic [31:0]       w_fd, w_pd;
    logic [FAW-1:0]    w_fraddr;
    logic [PAW-1:0]    w_praddr;

    assign w_type    = t_req'(req.req_type);
    assign req.ready = (r_state == S_IDLE) && !i_q_full;
    assign w_accept  = req.valid && req.ready;
    assign w_coef_ok = (32'(req.prec_segment) < MAX_PREC_BREAKS)
                    && (32'(req.frag_segment) < MAX_FRAG_BREAKS);

    // clamped break counts
    always_comb begin
        if (i_frag_cnt < 6'd3) begin
            w_nf = FCW'(3);
        end else if (32'(i_frag_cnt) > MAX_FRAG_BREAKS) begin
            w_nf = FCW'(MAX_FRAG_BREAKS);
        end else begin
            w_nf = FCW'(i_frag_cnt);
        end
        if (i_prec_cnt < 6'd3) begin
            w_np = PCW'(3);
        end else if (32'(i_prec_cnt) > MAX_PREC_BREAKS) begin
            w_np = PCW'(MAX_PREC_BREAKS);
        end else begin
            w_np = PCW'(i_prec_cnt);
        end
        w_nmax = (IW'(w_nf) > IW'(w_np)) ? IW'(w_nf) : IW'(w_np);
    end

    // segment from count of smaller breaks, clamped to count-2
    always_comb begin
        w_segf = (r_kf == '0) ? '0 : r_kf - 1'b1;
        if (w_segf > w_nf - FCW'(2)) begin
            w_segf = w_nf - FCW'(2);
        end
        w_segp = (r_kp == '0) ? '0 : r_kp - 1'b1;
        if (w_segp > w_np - PCW'(2)) begin
            w_segp = w_np - PCW'(2);
        end
    end

    assign w_fraddr = (r_state == S_SEG) ? w_segf[FAW-1:0] : r_idx[FAW-1:0];
    assign w_praddr = (r_state == S_SEG) ? w_segp[PAW-1:0] : r_idx[PAW-1:0];

    // break tables
    bse_ram #(.WIDTH(MASS_W), .DEPTH(MAX_FRAG_BREAKS)) u_frag_tab (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_type == REQ_FRAG
                  && 32'(req.break_slot) < MAX_FRAG_BREAKS),
        .i_waddr (FAW'(req.break_slot)),
        .i_wdata (req.break_mass),
        .i_raddr (w_fraddr),
        .o_rdata (w_fd)
    );

    bse_ram #(.WIDTH(MASS_W), .DEPTH(MAX_PREC_BREAKS)) u_prec_tab (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_type == REQ_PREC
                  && 32'(req.break_slot) < MAX_PREC_BREAKS),
        .i_waddr (PAW'(req.break_slot)),
        .i_wdata (req.break_mass),
        .i_raddr (w_praddr),
        .o_rdata (w_pd)
    );

    // range check on the captured end breaks
    assign w_oor = (r_fm >= r_pm) || (r_fm <= r_f0) || (r_fm >= r_fn2)
                || (r_pm <= r_p0) || (r_pm >= r_pn2);

    // queue push: coefficient loads pass straight through, queries after search
    always_comb begin
        o_q_job  = '0;
        o_q_push = 1'b0;
        if (r_state == S_PUSH) begin
            o_q_push      = !i_q_full;
            o_q_job.oor   = w_oor;
            o_q_job.p_seg = SEG_W'(r_segp);
            o_q_job.f_seg = SEG_W'(r_segf);
            o_q_job.x_off = (r_fm > r_fs) ? r_fm - r_fs : '0;
            o_q_job.y_off = (r_pm > r_ps) ? r_pm - r_ps : '0;
        end else begin
            o_q_push        = w_accept && w_type == REQ_COEF && w_coef_ok;
            o_q_job.is_coef = 1'b1;
            o_q_job.p_seg   = SEG_W'(req.prec_segment);
            o_q_job.f_seg   = SEG_W'(req.frag_segment);
            o_q_job.slot    = req.coef_slot;
            o_q_job.value   = req.coef_value;
        end
    end

    // sequencer: sweep both tables, then read the segment start breaks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rv    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_rv  <= 1'b0;
                    r_idx <= '0;
                    r_kf  <= '0;
                    r_kp  <= '0;
                    if (w_accept && w_type == REQ_EVAL) begin
                        r_pm    <= req.prec_mass;
                        r_fm    <= req.frag_mass;
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (r_idx < w_nmax) begin
                        r_rv   <= 1'b1;
                        r_ridx <= r_idx;
                        r_idx  <= r_idx + 1'b1;
                    end else begin
                        r_rv <= 1'b0;
                        if (!r_rv) begin
                            r_state <= S_SEG;
                        end
                    end
                    if (r_rv && r_ridx < IW'(w_nf)) begin
                        if (r_ridx == '0) begin
                            r_f0 <= w_fd;
                        end
                        if (r_ridx == IW'(w_nf - FCW'(2))) begin
                            r_fn2 <= w_fd;
                        end
                        if (w_fd < r_fm) begin
                            r_kf <= r_kf + 1'b1;
                        end
                    end
                    if (r_rv && r_ridx < IW'(w_np)) begin
                        if (r_ridx == '0) begin
                            r_p0 <= w_pd;
                        end
                        if (r_ridx == IW'(w_np - PCW'(2))) begin
                            r_pn2 <= w_pd;
                        end
                        if (w_pd < r_pm) begin
                            r_kp <= r_kp + 1'b1;
                        end
                    end
                end
                S_SEG: begin
                    r_segf  <= w_segf;
                    r_segp  <= w_segp;
                    r_state <= S_SEGW;
                end
                S_SEGW: begin
                    r_fs    <= w_fd;
                    r_ps    <= w_pd;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bse_back.sv
// bse_back: coefficient store and Horner evaluation with a shared multiply-add unit
// depends on bse_pkg, bse_rsp_if, bse_ram
`default_nettype none

module bse_back import bse_pkg::*; #(
    parameter int MAX_FRAG_BREAKS = MAX_FRAG_BREAKS_DEF,
    parameter int MAX_PREC_BREAKS = MAX_PREC_BREAKS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_empty,
    input  wire t_job i_head,
    output logic      o_q_pop,
    bse_rsp_if.source rsp
);

    localparam int FAW = $clog2(MAX_FRAG_BREAKS);
    localparam int PAW = $clog2(MAX_PREC_BREAKS);
    localparam int CAW = PAW + FAW + SLOT_W;
    localparam int CDEPTH = (1 << PAW) * (1 << FAW) * COEFS_PER_CELL;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(COEFS_PER_CELL - 1);

    typedef enum logic [2:0] {B_IDLE, B_RD, B_DAT, B_M2, B_M3, B_OUT} t_state;

    t_state                    r_state;
    logic [PAW-1:0]            r_pseg;
    logic [FAW-1:0]            r_fseg;
    logic [SLOT_W-1:0]         r_k;
    logic [31:0]               r_xo, r_yo;
    logic signed [COEF_W-1:0]  r_row, r_v;
    logic                      r_to_v;
    // multiply-add unit operands and partial products
    logic [COEF_W-1:0]         r_mag;
    logic                      r_neg;
    logic [31:0]               r_off;
    logic signed [COEF_W-1:0]  r_add;
    logic [55:0]               r_phi, r_plo;
    // result registers
    logic signed [COEF_W-1:0]  r_val;
    logic                      r_oor;

    logic signed [COEF_W-1:0]  w_cd;
    logic [63:0]               w_p, w_pc;
    logic signed [COEF_W+1:0]  w_m, w_sum;
    logic signed [COEF_W-1:0]  w_res;
    logic [CAW-1:0]            w_waddr, w_raddr;

    assign o_q_pop          = (r_state == B_IDLE) && !i_q_empty;
    assign rsp.valid        = (r_state == B_OUT);
    assign rsp.spline_value = r_val;
    assign rsp.out_of_range = r_oor;

    assign w_waddr = {i_head.p_seg[PAW-1:0], i_head.f_seg[FAW-1:0], i_head.slot};
    assign w_raddr = {r_pseg, r_fseg, r_k};

    // coefficient store, one cell of 16 per segment pair
    bse_ram #(.WIDTH(COEF_W), .DEPTH(CDEPTH))
    u_coef (
        .i_clk   (i_clk),
        .i_we    (o_q_pop && i_head.is_coef),
        .i_waddr (w_waddr),
        .i_wdata (i_head.value),
        .i_raddr (w_raddr),
        .o_rdata (w_cd)
    );

    // product rounding, sign restore and saturating add
    always_comb begin
        w_p = {2'b00, r_phi, 6'b000000} + ((64'(r_plo) + 64'h2_0000) >> 18);
        if (r_neg) begin
            w_pc = (w_p > 64'h8000_0000_0000) ? 64'h8000_0000_0000 : w_p;
            w_m  = -$signed({2'b00, w_pc[COEF_W-1:0]});
        end else begin
            w_pc = (w_p > 64'h7FFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF : w_p;
            w_m  = $signed({2'b00, w_pc[COEF_W-1:0]});
        end
        w_sum = w_m + {{2{r_add[COEF_W-1]}}, r_add};
        w_res = sat48(w_sum);
    end

    // evaluation sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            unique case (r_state)
                B_IDLE: begin
                    if (!i_q_empty && !i_head.is_coef) begin
                        r_pseg <= i_head.p_seg[PAW-1:0];
                        r_fseg <= i_head.f_seg[FAW-1:0];
                        r_xo   <= i_head.x_off;
                        r_yo   <= i_head.y_off;
                        r_k    <= '0;
                        if (i_head.oor) begin
                            r_val   <= NEG_ONE_Q40;
                            r_oor   <= 1'b1;
                            r_state <= B_OUT;
                        end else begin
                            r_oor   <= 1'b0;
                            r_state <= B_RD;
                        end
                    end
                end
                B_RD: begin
                    r_state <= B_DAT;
                end
                B_DAT: begin
                    if (r_k[1:0] == 2'd0) begin
                        r_row   <= w_cd;
                        r_k     <= r_k + 1'b1;
                        r_state <= B_RD;
                    end else begin
                        r_neg   <= r_row[COEF_W-1];
                        r_mag   <= r_row[COEF_W-1] ? (~r_row + 1'b1) : r_row;
                        r_off   <= r_yo;
                        r_add   <= w_cd;
                        r_to_v  <= 1'b0;
                        r_state <= B_M2;
                    end
                end
                B_M2: begin
                    r_phi   <= r_mag[47:24] * r_off;
                    r_plo   <= r_mag[23:0] * r_off;
                    r_state <= B_M3;
                end
                B_M3: begin
                    if (!r_to_v) begin
                        r_row <= w_res;
                        if (r_k[1:0] == 2'd3) begin
                            if (r_k == SLOT_W'(3)) begin
                                r_v     <= w_res;
                                r_k     <= r_k + 1'b1;
                                r_state <= B_RD;
                            end else begin
                                // fold the finished row into the outer polynomial
                                r_neg   <= r_v[COEF_W-1];
                                r_mag   <= r_v[COEF_W-1] ? (~r_v + 1'b1) : r_v;
                                r_off   <= r_xo;
                                r_add   <= w_res;
                                r_to_v  <= 1'b1;
                                r_state <= B_M2;
                            end
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= B_RD;
                        end
                    end else begin
                        r_v <= w_res;
                        if (r_k == SLOT_LAST) begin
                            r_val   <= w_res;
                            r_state <= B_OUT;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= B_RD;
                        end
                    end
                end
                B_OUT: begin
                    if (rsp.ready) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/bicubic_spline_evaluator_core.sv
// bicubic_spline_evaluator_core: top level, configuration port and front/queue/back wiring
// depends on bse_pkg, bse_req_if, bse_rsp_if, bse_front, bse_queue, bse_back
//
// Usage:
//   i_req carries requests (valid/ready). Load requests write the fragment or
//   precursor break tables or one coefficient and give no result. An
//   evaluate request gives one transfer on o_rsp with the spline value, or
//   -1.0 with out_of_range set when the query is rejected. The front sweeps
//   both break tables one entry a cycle; the back reads the 16 coefficients
//   one at a time from the coefficient memory port and runs them through one
//   shared multiply-add unit. Throughput is set by the back; a four-entry
//   queue lets the front search the next query while the back works. When
//   o_rsp stalls the result register holds, the queue fills, and then
//   i_req.ready drops. Reset sets both break counts to 32 and empties the
//   queue; the tables and coefficients stay undefined until loaded. Break
//   counts are written over the APB port at 0 and 4; the user must write
//   them only while the block is idle; the block does not enforce it.
`default_nettype none

module bicubic_spline_evaluator_core import bse_pkg::*; #(
    parameter int MAX_FRAG_BREAKS = MAX_FRAG_BREAKS_DEF,
    parameter int MAX_PREC_BREAKS = MAX_PREC_BREAKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bse_req_if.sink          i_req,
    bse_rsp_if.source        o_rsp,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [2:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic      [31:0] o_prdata,
    output logic             o_pready
);

    logic [CNT_W-1:0] r_frag_cnt, r_prec_cnt;
    t_cfg             w_idx;
    logic             w_q_push, w_q_pop, w_q_full, w_q_empty;
    t_job             w_q_job, w_q_head;

    assign o_pready = 1'b1;
    assign w_idx    = t_cfg'(i_paddr[2]);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frag_cnt <= CNT_RESET;
            r_prec_cnt <= CNT_RESET;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (w_idx)
                CFG_FRAG_CNT: r_frag_cnt <= i_pwdata[CNT_W-1:0];
                CFG_PREC_CNT: r_prec_cnt <= i_pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (w_idx)
            CFG_FRAG_CNT: o_prdata = 32'(r_frag_cnt);
            CFG_PREC_CNT: o_prdata = 32'(r_prec_cnt);
            default:      o_prdata = '0;
        endcase
    end

    bse_front #(.MAX_FRAG_BREAKS(MAX_FRAG_BREAKS), .MAX_PREC_BREAKS(MAX_PREC_BREAKS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req        (i_req),
        .i_frag_cnt (r_frag_cnt),
        .i_prec_cnt (r_prec_cnt),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_job    (w_q_job)
    );

    bse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_q_job),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    bse_back #(.MAX_FRAG_BREAKS(MAX_FRAG_BREAKS), .MAX_PREC_BREAKS(MAX_PREC_BREAKS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_head    (w_q_head),
        .o_q_pop   (w_q_pop),
        .rsp       (o_rsp)
    );

endmodule

`default_nettype wire

FILE: sim/bicubic_spline_evaluator_core_tb.sv
// testbench for bicubic_spline_evaluator_core: loads break tables and coefficients,
// sends evaluate queries and checks each result against a bit-true predictor
// depends on bse_pkg, bse_req_if, bse_rsp_if and the evaluator rtl
`default_nettype none

module bicubic_spline_evaluator_core_tb;
    import bse_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBRK       = 32;
    localparam int CYCLE_MAX  = 1_000_000;
    localparam int SETTLE     = 200;
    localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_MAX = 48'h8000_0000_0000;

    typedef struct {
        logic signed [47:0] value;
        logic               oor;
    } t_spline_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_psel, i_penable, i_pwrite;
    logic [2:0]  i_paddr;
    logic [31:0] i_pwdata;
    logic [31:0] o_prdata;
    logic        o_pready;

    bse_req_if req_ch ();
    bse_rsp_if rsp_ch ();

    bicubic_spline_evaluator_core i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_ch),
        .o_rsp     (rsp_ch),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    always #10 i_clk = ~i_clk;

    // shadow of the block state
    logic [31:0]        frag_tbl [NBRK];
    logic [31:0]        prec_tbl [NBRK];
    logic signed [47:0] coef_mem [NBRK*NBRK*16];
    bit                 coef_wr  [NBRK*NBRK*16];
    logic [5:0]         frag_cnt_reg, prec_cnt_reg;
    bit                 tables_sorted;

    t_spline_res spline_pending[$];
    int          n_items;
    int          burst_left;
    int          n_errors;
    longint      cycles = 0;

    // ---------------- predictor ----------------

    function automatic int active_count(logic [5:0] n);
        if (n < 3) return 3;
        if (n > NBRK) return NBRK;
        return int'(n);
    endfunction

    function automatic logic signed [47:0] sat_sum(logic signed [47:0] a, logic signed [47:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'($signed(POS_MAX))) return POS_MAX;
        if (s < longint'($signed(NEG_MAX))) return NEG_MAX;
        return s[47:0];
    endfunction

    // q8.40 times unsigned q14.18 offset, rounded half away from zero, saturated
    function automatic logic signed [47:0] scale_by_offset(logic signed [47:0] r,
                                                            logic [31:0] off);
        logic [63:0] mag, hi, lo, p, off64;
        logic        neg;
        neg = r[47];
        mag = {{16{r[47]}}, r};
        if (neg) mag = -mag;
        off64 = {32'd0, off};
        hi = mag >> 24;
        lo = mag & 64'hFF_FFFF;
        p = ((hi * off64) << 6) + ((lo * off64 + 64'h2_0000) >> 18);
        if (neg) begin
            if (p > {16'd0, NEG_MAX}) p = {16'd0, NEG_MAX};
            p = -p;
            return p[47:0];
        end
        if (p > {16'd0, POS_MAX}) p = {16'd0, POS_MAX};
        return p[47:0];
    endfunction

    function automatic int segment_of(bit is_prec, int n, logic [31:0] m);
        int k;
        k = 0;
        for (int i = 0; i < n; i++) begin
            if ((is_prec ? prec_tbl[i] : frag_tbl[i]) < m) k++;
        end
        k = (k == 0) ? 0 : k - 1;
        if (k > n - 2) k = n - 2;
        return k;
    endfunction

    function automatic bit query_rejected(logic [31:0] pm, logic [31:0] fm);
        int nf, np;
        nf = active_count(frag_cnt_reg);
        np = active_count(prec_cnt_reg);
        return (fm >= pm) || (fm <= frag_tbl[0]) || (fm >= frag_tbl[nf-2]) ||
               (pm <= prec_tbl[0]) || (pm >= prec_tbl[np-2]);
    endfunction

    function automatic int cell_base(int si, int sj);
        return (si * NBRK + sj) * 16;
    endfunction

    function automatic bit cell_loaded(int si, int sj);
        for (int k = 0; k < 16; k++) begin
            if (!coef_wr[cell_base(si, sj) + k]) return 0;
        end
        return 1;
    endfunction

    // evaluate query; a rejected query is -1.0 with the flag set
    function automatic t_spline_res spline_eval(logic [31:0] pm, logic [31:0] fm);
        t_spline_res        res;
        int                 si, sj, b;
        logic [31:0]        xo, yo;
        logic signed [47:0] v, row;
        if (query_rejected(pm, fm)) begin
            res.value = NEG_ONE_Q40;
            res.oor = 1'b1;
            return res;
        end
        si = segment_of(1, active_count(prec_cnt_reg), pm);
        sj = segment_of(0, active_count(frag_cnt_reg), fm);
        yo = (pm > prec_tbl[si]) ? pm - prec_tbl[si] : 32'd0;
        xo = (fm > frag_tbl[sj]) ? fm - frag_tbl[sj] : 32'd0;
        b = cell_base(si, sj);
        v = '0;
        for (int i = 3; i >= 0; i--) begin
            row = coef_mem[b + 12 - 4*i];
            for (int j = 2; j >= 0; j--) begin
                row = sat_sum(scale_by_offset(row, yo), coef_mem[b + 15 - 4*i - j]);
            end
            v = (i == 3) ? row : sat_sum(scale_by_offset(v, xo), row);
        end
        res.value = v;
        res.oor = 1'b0;
        return res;
    endfunction

    // a query is safe to send when it is rejected or lands in a fully loaded cell
    function automatic bit query_safe(logic [31:0] pm, logic [31:0] fm);
        if (query_rejected(pm, fm)) return 1;
        return cell_loaded(segment_of(1, active_count(prec_cnt_reg), pm),
                           segment_of(0, active_count(frag_cnt_reg), fm));
    endfunction

    // ---------------- request side ----------------

    task automatic send_req(t_req kind, logic [31:0] pm, logic [31:0] fm, logic [31:0] bm,
                            logic [4:0] bslot, logic [4:0] pseg, logic [4:0] fseg,
                            logic [3:0] cslot, logic signed [47:0] cval);
        req_ch.valid          <= 1'b1;
        req_ch.req_type       <= kind;
        req_ch.prec_mass      <= pm;
        req_ch.frag_mass      <= fm;
        req_ch.break_mass     <= bm;
        req_ch.break_slot     <= bslot;
        req_ch.prec_segment   <= pseg;
        req_ch.frag_segment   <= fseg;
        req_ch.coef_slot      <= cslot;
        req_ch.coef_value     <= cval;
        do @(posedge i_clk); while (!req_ch.ready);
        n_items++;
        case (kind)
            REQ_FRAG: frag_tbl[bslot] = bm;
            REQ_PREC: prec_tbl[bslot] = bm;
            REQ_COEF: begin
                coef_mem[cell_base(pseg, fseg) + cslot] = cval;
                coef_wr[cell_base(pseg, fseg) + cslot] = 1'b1;
            end
            default: spline_pending.push_back(spline_eval(pm, fm));
        endcase
        // sender bursts and gaps
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
        end else begin
            burst_left--;
        end
    endtask

    task automatic send_query(logic [31:0] pm, logic [31:0] fm);
        send_req(REQ_EVAL, pm, fm, $urandom, 5'($urandom), 5'($urandom), 5'($urandom),
                 4'($urandom), 48'({$urandom, $urandom}));
    endtask

    task automatic send_break(t_req kind, int slot, logic [31:0] m);
        send_req(kind, $urandom, $urandom, m, slot[4:0], 5'($urandom), 5'($urandom),
                 4'($urandom), 48'({$urandom, $urandom}));
    endtask

    task automatic send_coef(int ps, int fs, int slot, logic signed [47:0] c);
        send_req(REQ_COEF, $urandom, $urandom, $urandom, 5'($urandom), ps[4:0], fs[4:0],
                 slot[3:0], c);
    endtask

    function automatic logic signed [47:0] rand_coef();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       return r[47:0];
            1:       return POS_MAX;
            2:       return NEG_MAX;
            3:       return {{7{r[40]}}, r[40:0]};
            default: return {{12{r[35]}}, r[35:0]};
        endcase
    endfunction

    // all 16 coefficients of one cell in shuffled order
    task automatic load_cell(int ps, int fs, int mode);
        int order[16];
        int k, t;
        for (k = 0; k < 16; k++) order[k] = k;
        for (k = 15; k > 0; k--) begin
            t = $urandom_range(0, k);
            {order[k], order[t]} = {order[t], order[k]};
        end
        for (k = 0; k < 16; k++) begin
            case (mode)
                1:       send_coef(ps, fs, order[k], POS_MAX);
                2:       send_coef(ps, fs, order[k], NEG_MAX);
                default: send_coef(ps, fs, order[k], rand_coef());
            endcase
        end
    endtask

    // ascending fragment breaks, all below the ascending precursor breaks
    task automatic load_sorted_tables();
        logic [31:0] f, p;
        int          fstep, pstep;
        fstep = 1 << $urandom_range(2, 24);
        pstep = 1 << $urandom_range(2, 25);
        f = $urandom_range(1, 1 << 20);
        p = 32'h4000_0000 + $urandom_range(0, 1 << 20);
        for (int k = 0; k < NBRK; k++) begin
            send_break(REQ_FRAG, k, f);
            send_break(REQ_PREC, k, p);
            f += $urandom_range(2, fstep);
            p += $urandom_range(2, pstep);
        end
        tables_sorted = 1;
    endtask

    task automatic load_random_tables();
        for (int k = 0; k < NBRK; k++) begin
            send_break(REQ_FRAG, k, ($urandom_range(0, 1)) ? $urandom : $urandom_range(0, 4096));
            send_break(REQ_PREC, k, $urandom);
        end
        tables_sorted = 0;
    endtask

    // mass inside segment s of a sorted table with n active entries
    function automatic logic [31:0] mass_in_seg(bit is_prec, int s, int n);
        logic [31:0] lo, hi;
        lo = (is_prec ? prec_tbl[s] : frag_tbl[s]) + 1;
        hi = is_prec ? prec_tbl[s+1] : frag_tbl[s+1];
        if (s + 1 == n - 2) hi = hi - 1;
        return $urandom_range(hi, lo);
    endfunction

    task automatic query_in_cell(int si, int sj);
        logic [31:0] pm, fm;
        pm = mass_in_seg(1, si, active_count(prec_cnt_reg));
        fm = mass_in_seg(0, sj, active_count(frag_cnt_reg));
        if (query_safe(pm, fm)) send_query(pm, fm);
        else send_query(fm, fm);
    endtask

    // random masses, near breaks or anywhere; falls back to a rejected query
    task automatic query_noise();
        logic [31:0] pm, fm;
        for (int tries = 0; tries < 20; tries++) begin
            pm = $urandom_range(0, 1) ? $urandom
                                       : prec_tbl[$urandom_range(0, NBRK-1)] + $urandom_range(0, 6) - 3;
            fm = $urandom_range(0, 1) ? $urandom
                                       : frag_tbl[$urandom_range(0, NBRK-1)] + $urandom_range(0, 6) - 3;
            if (query_safe(pm, fm)) begin
                send_query(pm, fm);
                return;
            end
        end
        send_query(pm, pm);
    endtask

    // ---------------- configuration ----------------

    task automatic cfg_write(t_cfg idx, logic [5:0] val);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= {idx, 2'b00};
        i_pwdata  <= {$urandom_range(0, 1) ? $urandom : 32'd0} & 32'hFFFF_FFC0 | val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
        if (idx == CFG_FRAG_CNT) frag_cnt_reg = val;
        else prec_cnt_reg = val;
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (spline_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_counts(logic [5:0] nf, logic [5:0] np);
        wait_idle();
        cfg_write(CFG_FRAG_CNT, nf);
        cfg_write(CFG_PREC_CNT, np);
    endtask

    // ---------------- tests ----------------

    task automatic test_directed();
        int nf, np;
        nf = active_count(frag_cnt_reg);
        np = active_count(prec_cnt_reg);
        load_sorted_tables();
        // saturation both ways, lowest cell
        load_cell(0, 0, 1);
        send_query(prec_tbl[1], frag_tbl[1]);
        load_cell(0, 0, 2);
        send_query(prec_tbl[1], frag_tbl[0] + 1);
        // top valid cell with ordinary coefficients
        load_cell(np - 3, nf - 3, 0);
        send_query(prec_tbl[np-2] - 1, frag_tbl[nf-2] - 1);
        send_query(prec_tbl[np-3] + 1, frag_tbl[nf-3] + 1);
        // range edges, fragment not below precursor, and the mass extremes
        send_query(prec_tbl[1], frag_tbl[0]);
        send_query(prec_tbl[1], frag_tbl[nf-2]);
        send_query(prec_tbl[0], frag_tbl[1]);
        send_query(prec_tbl[np-2], frag_tbl[1]);
        send_query(frag_tbl[1], frag_tbl[1]);
        send_query(frag_tbl[1], prec_tbl[1]);
        send_query(32'd0, 32'd0);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_random(int n_req);
        int stop_at, nf, np, si, sj, act;
        stop_at = n_items + n_req;
        nf = active_count(frag_cnt_reg);
        np = active_count(prec_cnt_reg);
        while (n_items < stop_at) begin
            act = $urandom_range(0, 99);
            si = $urandom_range(0, np - 3);
            sj = $urandom_range(0, nf - 3);
            if (act < 6) begin
                if ($urandom_range(0, 3) == 0) load_cell($urandom_range(0, 31), $urandom_range(0, 31), 0);
                else load_cell(si, sj, 0);
            end else if (act < 75 && tables_sorted) begin
                if (!cell_loaded(si, sj)) load_cell(si, sj, 0);
                query_in_cell(si, sj);
            end else if (act < 97) begin
                query_noise();
            end else if (act < 99) begin
                send_coef($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 15),
                          rand_coef());
            end else begin
                // hold off until everything sent so far has come back
                wait_idle();
            end
        end
    endtask

    task automatic test_counts();
        logic [5:0] settings[6][2];
        settings = '{'{6'd3, 6'd3}, '{6'd32, 6'd32}, '{6'd0, 6'd63},
                     '{6'd5, 6'd17}, '{6'd2, 6'd40}, '{6'd31, 6'd4}};
        foreach (settings[k]) begin
            set_counts(settings[k][0], settings[k][1]);
            if (k % 2 == 1) load_sorted_tables();
            test_random(150);
        end
    endtask

    task automatic test_unsorted();
        set_counts($urandom_range(3, 32), $urandom_range(3, 32));
        load_random_tables();
        for (int k = 0; k < 6; k++) begin
            load_cell($urandom_range(0, active_count(prec_cnt_reg) - 2),
                      $urandom_range(0, active_count(frag_cnt_reg) - 2), 0);
        end
        test_random(180);
    endtask

    // ---------------- result side ----------------

    int stall_phase = 0;
    int stall_mode = 0;

    // receiver stalls on a pattern that is redrawn at random from four modes
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0:       rsp_ch.ready <= 1'b1;
            1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
            2:       rsp_ch.ready <= (stall_phase % 32) >= 24;
            default: rsp_ch.ready <= $urandom_range(0, 7) != 0;
        endcase
    end

    // compare every result transfer with the oldest pending value
    always @(posedge i_clk) begin
        t_spline_res want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (spline_pending.size() == 0) begin
                $display("%0t: unexpected result value=%h oor=%b", $time,
                         rsp_ch.spline_value, rsp_ch.out_of_range);
                n_errors++;
            end else begin
                want = spline_pending.pop_front();
                if (rsp_ch.spline_value !== want.value) begin
                    $display("%0t: spline_value expected %h actual %h", $time,
                             want.value, rsp_ch.spline_value);
                    n_errors++;
                end
                if (rsp_ch.out_of_range !== want.oor) begin
                    $display("%0t: out_of_range expected %b actual %b", $time,
                             want.oor, rsp_ch.out_of_range);
                    n_errors++;
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        n_items       = 0;
        n_errors      = 0;
        burst_left    = 4;
        tables_sorted = 0;
        frag_cnt_reg  = CNT_RESET;
        prec_cnt_reg  = CNT_RESET;
        foreach (coef_wr[k]) coef_wr[k] = 1'b0;
        i_psel    = 1'b0;
        i_penable = 1'b0;
        i_pwrite  = 1'b0;
        i_paddr   = '0;
        i_pwdata  = '0;
        req_ch.valid          = 1'b0;
        req_ch.req_type       = REQ_EVAL;
        req_ch.prec_mass      = '0;
        req_ch.frag_mass      = '0;
        req_ch.break_mass     = '0;
        req_ch.break_slot     = '0;
        req_ch.prec_segment   = '0;
        req_ch.frag_segment   = '0;
        req_ch.coef_slot      = '0;
        req_ch.coef_value     = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(200);
        test_counts();
        test_unsorted();

        req_ch.valid <= 1'b0;
        while (spline_pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
